// ===== rtl/tap_tempo_bpm_macros.svh =====
// Assertion macros shared by the tap tempo checker.
// Needs a clk and rst in scope where used.
`ifndef TAP_TEMPO_BPM_MACROS_SVH
`define TAP_TEMPO_BPM_MACROS_SVH

// same-cycle implication
`define TTB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tap_tempo_bpm check failed");

// next-cycle implication
`define TTB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tap_tempo_bpm check failed");

`endif

// ===== rtl/ttb_pkg.sv =====
// Shared types and constants for the tap tempo block.
// No dependencies.
`default_nettype none

package ttb_pkg;

  localparam int DATA_W   = 32;
  localparam int STEP_W   = 6;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 16;
  localparam int GAP_W    = 16;
  localparam int BPM_W    = 8;
  localparam int TEMPO_W  = 16;

  localparam int DEFAULT_HISTORY_DEPTH = 4;

  localparam logic [TEMPO_W-1:0] TEMPO_NUM = 16'd60000;
  localparam logic [GAP_W-1:0]   MAX_GAP_RST = 16'd2000;
  localparam logic [BPM_W-1:0]   MIN_BPM_RST = 8'd30;
  localparam logic [BPM_W-1:0]   MAX_BPM_RST = 8'd240;

  typedef enum logic [CFG_IW-1:0] {
    CFG_MAX_GAP = 2'd0,
    CFG_MIN_BPM = 2'd1,
    CFG_MAX_BPM = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

`default_nettype wire

// ===== rtl/ttb_div.sv =====
// Restoring divider, one quotient bit per cycle, for the tap tempo block.
// Depends on ttb_pkg.
`default_nettype none

module ttb_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ttb_pkg::div_req_t          req,
  input  wire logic [ttb_pkg::DATA_W-1:0] dividend,
  input  wire logic [ttb_pkg::DATA_W-1:0] divisor,
  output logic                            done,
  output logic [ttb_pkg::DATA_W-1:0]      quotient
);
  import ttb_pkg::*;

  logic                busy;
  logic [STEP_W-1:0]   cnt;
  logic [DATA_W:0]     rem;
  logic [DATA_W-1:0]   dvd;
  logic [DATA_W-1:0]   dsr;
  logic [DATA_W:0]     rem_sh;
  logic                fits;

  assign rem_sh = {rem[DATA_W-1:0], dvd[DATA_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= '0;
      dvd      <= dividend;
      dsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? rem_sh - {1'b0, dsr} : rem_sh;
      dvd      <= {dvd[DATA_W-2:0], 1'b0};
      quotient <= {quotient[DATA_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tap_tempo_bpm.sv =====
// Tap tempo: each tap item (ms timestamp) yields one result item, valid with a
// clamped tempo once two or more taps are held in the ring of HISTORY_DEPTH.
// A tap is stored, then the mean interval and then 60000 / mean run through
// one shared restoring divider at one quotient bit per cycle (32 + 16
// steps); the second division is skipped when the mean interval is zero,
// and both when fewer than two taps are held. tap_ready is high only while
// no tap is in progress, so the next tap is taken in the cycle after the
// result is loaded at the earliest. A finished result waits in the output
// register while the next tap is accepted; a tap whose result is ready holds
// in its last state for as long as the previous result stays unaccepted.
// Config writes are always taken (cfg_ready is tied high); indexes past the
// register list are ignored. Depends on ttb_pkg and ttb_div.
`default_nettype none

module tap_tempo_bpm #(
  parameter int HISTORY_DEPTH = ttb_pkg::DEFAULT_HISTORY_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       tap_valid,
  output logic                            tap_ready,
  input  wire logic [ttb_pkg::DATA_W-1:0] tap_time_ms,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output logic                            bpm_valid,
  output logic [ttb_pkg::BPM_W-1:0]       bpm,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [ttb_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [ttb_pkg::CFG_DW-1:0] cfg_data
);
  import ttb_pkg::*;

  localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = $clog2(2 * HISTORY_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
  localparam logic [IW-1:0] LAST_SLOT = IW'(HISTORY_DEPTH - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_STORE = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_DIV1  = 7'b0001000,
    S_DIV2  = 7'b0010000,
    S_CLAMP = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [GAP_W-1:0]  max_gap;
  logic [BPM_W-1:0]  min_bpm;
  logic [BPM_W-1:0]  max_bpm;

  logic [DATA_W-1:0] tap_mem [HISTORY_DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] now;
  logic [DATA_W-1:0] last_tap;
  logic [IW-1:0]     slot;
  logic [CW-1:0]     held;
  logic [BPM_W-1:0]  tempo;
  logic              tempo_ok;

  logic [DATA_W-1:0] gap;
  logic              clear;
  logic [CW-1:0]     held_next;
  logic [SW-1:0]     rd_sum;
  logic [SW-1:0]     rd_idx;
  logic [IW-1:0]     rd_addr;

  div_req_t          div_req;
  logic [DATA_W-1:0] div_dividend;
  logic [DATA_W-1:0] div_divisor;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;

  logic [TEMPO_W-1:0] quo16;
  logic [TEMPO_W-1:0] lo_clamped;

  assign tap_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap <= MAX_GAP_RST;
      min_bpm <= MIN_BPM_RST;
      max_bpm <= MAX_BPM_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_GAP: max_gap <= cfg_data;
        CFG_MIN_BPM: min_bpm <= cfg_data[BPM_W-1:0];
        CFG_MAX_BPM: max_bpm <= cfg_data[BPM_W-1:0];
        default: ;
      endcase
    end
  end

  // history bookkeeping
  assign gap   = now - last_tap;
  assign clear = (held != '0) && (gap > {{(DATA_W-GAP_W){1'b0}}, max_gap});
  assign held_next = clear ? CW'(1) : ((held < DEPTH_C) ? held + CW'(1) : DEPTH_C);
  assign rd_sum  = SW'(slot) + SW'(1) + SW'(HISTORY_DEPTH) - SW'(held_next);
  assign rd_idx  = (rd_sum >= SW'(HISTORY_DEPTH)) ? rd_sum - SW'(HISTORY_DEPTH) : rd_sum;
  assign rd_addr = rd_idx[IW-1:0];

  always_ff @(posedge clk) begin
    if (state == S_STORE) begin
      tap_mem[slot] <= now;
      rd_data       <= tap_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      held <= '0;
    end else if (state == S_STORE) begin
      slot <= (slot == LAST_SLOT) ? '0 : slot + IW'(1);
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tap_valid && tap_ready) begin
      now <= tap_time_ms;
    end
    if (state == S_STORE) begin
      last_tap <= now;
    end
  end

  // shared divider: mean interval first, then tempo
  always_comb begin
    div_req      = '0;
    div_dividend = now - rd_data;
    div_divisor  = {{(DATA_W-CW){1'b0}}, held - CW'(1)};
    if (state == S_LOAD && held >= CW'(2)) begin
      div_req.start = 1'b1;
      div_req.steps = STEP_W'(DATA_W);
    end else if (state == S_DIV1 && div_done && div_quo != '0) begin
      div_req.start = 1'b1;
      div_req.steps = STEP_W'(TEMPO_W);
      div_dividend  = {TEMPO_NUM, {(DATA_W-TEMPO_W){1'b0}}};
      div_divisor   = div_quo;
    end
  end

  ttb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign quo16      = div_quo[TEMPO_W-1:0];
  assign lo_clamped = (quo16 < {8'b0, min_bpm}) ? {8'b0, min_bpm} : quo16;

  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: begin
        tempo    <= '0;
        tempo_ok <= held >= CW'(2);
      end
      S_DIV1: begin
        if (div_done && div_quo == '0) begin
          tempo <= max_bpm;
        end
      end
      S_CLAMP: begin
        tempo <= (lo_clamped > {8'b0, max_bpm}) ? max_bpm : lo_clamped[BPM_W-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (tap_valid) state_next = S_STORE;
      S_STORE: state_next = S_LOAD;
      S_LOAD:  state_next = (held >= CW'(2)) ? S_DIV1 : S_DONE;
      S_DIV1: begin
        if (div_done) begin
          state_next = (div_quo == '0) ? S_DONE : S_DIV2;
        end
      end
      S_DIV2:  if (div_done) state_next = S_CLAMP;
      S_CLAMP: state_next = S_DONE;
      S_DONE:  if (!res_valid || res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_DONE && (!res_valid || res_ready)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!res_valid || res_ready)) begin
      bpm_valid <= tempo_ok;
      bpm       <= tempo;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tap_tempo_bpm_checker.sv =====
// Port-level checks for tap_tempo_bpm, bound onto the top level.
// Depends on tap_tempo_bpm_macros.svh and ttb_pkg.
`default_nettype none
`include "tap_tempo_bpm_macros.svh"

module tap_tempo_bpm_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       tap_valid,
  input wire logic                       tap_ready,
  input wire logic [ttb_pkg::DATA_W-1:0] tap_time_ms,
  input wire logic                       res_valid,
  input wire logic                       res_ready,
  input wire logic                       bpm_valid,
  input wire logic [ttb_pkg::BPM_W-1:0]  bpm,
  input wire logic                       cfg_valid,
  input wire logic                       cfg_ready,
  input wire logic [ttb_pkg::CFG_IW-1:0] cfg_index,
  input wire logic [ttb_pkg::CFG_DW-1:0] cfg_data
);
  import ttb_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{tap_time_ms, cfg_valid, cfg_ready, cfg_index, cfg_data};

  `TTB_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(bpm) && $stable(bpm_valid))
  `TTB_ASSERT_NOW(a_invalid_zero, res_valid && !bpm_valid, bpm == '0)
  `TTB_ASSERT_NEXT(a_busy_after_tap, tap_valid && tap_ready, !tap_ready)
  `TTB_ASSERT_NOW(a_result_from_busy, $rose(res_valid), $past(!tap_ready))

endmodule

bind tap_tempo_bpm tap_tempo_bpm_checker u_checker (.*);

`default_nettype wire
